@@ rtl/core/sscf_pkg.sv @@
package sscf_pkg;

  typedef enum logic [1:0] {
    M_SEEK0 = 2'd0,
    M_SEEK1 = 2'd1,
    M_INIT  = 2'd2,
    M_NEXT  = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t       mode;
    logic [6:0]  fill_count;
    logic [7:0]  first_symbol_hold;
    logic        saw_sync0;
    logic        section_poor;
    logic [3:0]  miss_run;
    logic [31:0] section_counter;
    logic [31:0] poor_counter;
    logic [31:0] lost_counter;
  } state_t;

  typedef struct packed {
    logic [7:0]  symbol;
    logic [6:0]  position;
    logic        last;
    logic        poor_sync;
    logic [31:0] sections_total;
    logic [31:0] poor_sync_total;
    logic [31:0] sync_lost_total;
  } result_t;

  localparam logic [3:0] MISS_LIMIT_RESET = 4'd4;
  localparam logic [3:0] MISS_RUN_MAX     = 4'd15;

endpackage

@@ rtl/core/subcode_section_framer.sv @@
// Subcode section framer: takes one frame per word (subcode symbol plus SYNC0
// and SYNC1 flags), finds SYNC0 followed by SYNC1, then cuts the stream into
// SECTION_LEN-symbol sections and streams each section out with its position,
// a last flag, a poor-sync flag and three wrapping 32-bit counters. A frame
// sits in the input register until the queue has room and is then resolved in a single pass
// into zero, one or two result words that go into a four-word output queue.
// The input side takes one frame per cycle as long as the queue has two free
// words; the output port delivers one word per cycle unless out_stall is set,
// so the sustained rate is set by the output port: one frame per cycle on
// mid-section frames, and the frame that commits a section's first two symbols
// yields two words.
// miss_limit (reset 4) may only be written while the block is idle.
module subcode_section_framer import sscf_pkg::*; #(
  parameter int SECTION_LEN = 98
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [3:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  subcode_symbol,
  input  logic        is_sync0,
  input  logic        is_sync1,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_symbol,
  output logic [6:0]  position,
  output logic        last,
  output logic        poor_sync,
  output logic [31:0] sections_total,
  output logic [31:0] poor_sync_total,
  output logic [31:0] sync_lost_total
);

  logic       miss_limit;
  logic [3:0] miss_limit_q;
  logic       in_full;
  logic [7:0] sym_q;
  logic       s0_q;
  logic       s1_q;
  logic       room;
  logic       fire;
  logic       accept;
  state_t     st;
  state_t     st_next;
  logic [1:0] res_count;
  logic [1:0] push_count;
  result_t    res0;
  result_t    res1;
  result_t    out_data;

  assign miss_limit = cfg_wen;
  assign fire       = in_full && room;
  assign in_stall   = in_full && !room;
  assign accept     = in_valid && !in_stall;
  assign push_count = fire ? res_count : 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      miss_limit_q <= MISS_LIMIT_RESET;
      in_full      <= 1'b0;
      st           <= '0;
    end else begin
      if (miss_limit) begin
        miss_limit_q <= cfg_wdata;
      end
      in_full <= accept || (in_full && !fire);
      if (fire) begin
        st <= st_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sym_q <= subcode_symbol;
      s0_q  <= is_sync0;
      s1_q  <= is_sync1;
    end
  end

  sscf_step #(
    .SectionLen(SECTION_LEN)
  ) u_step (
    .st        (st),
    .symbol    (sym_q),
    .sync0     (s0_q),
    .sync1     (s1_q),
    .miss_limit(miss_limit_q),
    .st_next   (st_next),
    .res_count (res_count),
    .res0      (res0),
    .res1      (res1)
  );

  sscf_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_count(push_count),
    .push0     (res0),
    .push1     (res1),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign out_symbol      = out_data.symbol;
  assign position        = out_data.position;
  assign last            = out_data.last;
  assign poor_sync       = out_data.poor_sync;
  assign sections_total  = out_data.sections_total;
  assign poor_sync_total = out_data.poor_sync_total;
  assign sync_lost_total = out_data.sync_lost_total;

  a_fill_in_range: assert property (@(posedge clk) disable iff (rst)
    (st.mode == M_INIT || st.mode == M_NEXT) |-> st.fill_count < 7'(SECTION_LEN))
    else $error("fill count beyond section length while locked");

  a_init_clean: assert property (@(posedge clk) disable iff (rst)
    st.mode == M_INIT |-> !st.section_poor && st.fill_count >= 7'd2)
    else $error("initial section marked poor or not committed");

  a_pair_layout: assert property (@(posedge clk) disable iff (rst)
    (fire && res_count == 2'd2) |->
      (res0.position == 7'd0 && res1.position == 7'd1 && !res0.last && !res1.last))
    else $error("committed pair not at positions 0 and 1");

endmodule

@@ rtl/core/sscf_step.sv @@
module sscf_step import sscf_pkg::*; #(
  parameter int SectionLen = 98
) (
  input  state_t      st,
  input  logic [7:0]  symbol,
  input  logic        sync0,
  input  logic        sync1,
  input  logic [3:0]  miss_limit,
  output state_t      st_next,
  output logic [1:0]  res_count,
  output result_t     res0,
  output result_t     res1
);

  logic [7:0] fill_inc;
  logic       sec_end;
  logic       sync_good;
  logic [3:0] run_inc;
  logic       lose;

  assign fill_inc  = {1'b0, st.fill_count} + 8'd1;
  assign sec_end   = fill_inc >= 8'(SectionLen);
  assign sync_good = st.saw_sync0 & sync1;
  assign run_inc   = (st.miss_run == MISS_RUN_MAX) ? MISS_RUN_MAX : st.miss_run + 4'd1;
  assign lose      = !sync_good && (run_inc >= miss_limit);

  // restart the SYNC0 search with this frame
  function automatic state_t seek0(input state_t s, input logic [7:0] sym, input logic s0);
    state_t r;
    r              = s;
    r.fill_count   = 7'd0;
    r.saw_sync0    = 1'b0;
    r.section_poor = 1'b0;
    r.mode         = M_SEEK0;
    if (s0) begin
      r.first_symbol_hold = sym;
      r.fill_count        = 7'd1;
      r.mode              = M_SEEK1;
    end
    return r;
  endfunction

  // one symbol into the committed section
  function automatic state_t take_one(input state_t s, input logic [7:0] inc, input logic done);
    state_t r;
    r = s;
    if (done) begin
      r.section_counter = s.section_counter + 32'd1;
      r.fill_count      = 7'd0;
      r.mode            = M_NEXT;
      r.saw_sync0       = 1'b0;
      r.section_poor    = 1'b0;
    end else begin
      r.fill_count = inc[6:0];
    end
    return r;
  endfunction

  always_comb begin
    st_next = st;
    case (st.mode)
      M_SEEK0: begin
        st_next = seek0(st, symbol, sync0);
      end
      M_SEEK1: begin
        if (sync1) begin
          st_next.mode         = M_INIT;
          st_next.section_poor = 1'b0;
          st_next.fill_count   = 7'd2;
        end else begin
          st_next.mode         = M_SEEK0;
          st_next.fill_count   = 7'd0;
          st_next.saw_sync0    = 1'b0;
          st_next.section_poor = 1'b0;
        end
      end
      M_INIT: begin
        st_next = take_one(st, fill_inc, sec_end);
      end
      M_NEXT: begin
        if (st.fill_count == 7'd0) begin
          st_next.first_symbol_hold = symbol;
          st_next.saw_sync0         = sync0;
          st_next.section_poor      = 1'b0;
          st_next.fill_count        = 7'd1;
        end else if (st.fill_count == 7'd1) begin
          if (sync_good) begin
            st_next.miss_run   = 4'd0;
            st_next.fill_count = 7'd2;
          end else begin
            st_next.poor_counter = st.poor_counter + 32'd1;
            if (lose) begin
              st_next              = seek0(st_next, symbol, sync0);
              st_next.miss_run     = 4'd0;
              st_next.lost_counter = st.lost_counter + 32'd1;
            end else begin
              st_next.miss_run     = run_inc;
              st_next.section_poor = 1'b1;
              st_next.fill_count   = 7'd2;
            end
          end
        end else begin
          st_next = take_one(st, fill_inc, sec_end);
        end
      end
      default: begin
        st_next = st;
      end
    endcase
  end

  always_comb begin
    res_count            = 2'd0;
    res0                 = '0;
    res0.sections_total  = st_next.section_counter;
    res0.poor_sync_total = st_next.poor_counter;
    res0.sync_lost_total = st_next.lost_counter;
    res1                 = res0;
    case (st.mode)
      M_SEEK1: begin
        if (sync1) begin
          res_count     = 2'd2;
          res0.symbol   = st.first_symbol_hold;
          res0.position = 7'd0;
          res1.symbol   = symbol;
          res1.position = 7'd1;
        end
      end
      M_INIT: begin
        res_count      = 2'd1;
        res0.symbol    = symbol;
        res0.position  = st.fill_count;
        res0.last      = sec_end;
        res0.poor_sync = st.section_poor;
      end
      M_NEXT: begin
        if (st.fill_count == 7'd1) begin
          if (!lose) begin
            res_count      = 2'd2;
            res0.symbol    = st.first_symbol_hold;
            res0.position  = 7'd0;
            res0.poor_sync = !sync_good;
            res1.symbol    = symbol;
            res1.position  = 7'd1;
            res1.poor_sync = !sync_good;
          end
        end else if (st.fill_count != 7'd0) begin
          res_count      = 2'd1;
          res0.symbol    = symbol;
          res0.position  = st.fill_count;
          res0.last      = sec_end;
          res0.poor_sync = st.section_poor;
        end
      end
      default: begin
        res_count = 2'd0;
      end
    endcase
  end

endmodule

@@ rtl/core/sscf_out_fifo.sv @@
module sscf_out_fifo import sscf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [1:0] push_count,
  input  result_t    push0,
  input  result_t    push1,
  output logic       room,
  output logic       out_valid,
  input  logic       out_stall,
  output result_t    out_data
);

  localparam int Depth = 4;
  localparam int AddrW = $clog2(Depth);

  result_t          mem [Depth];
  logic [AddrW-1:0] rd_ptr;
  logic [AddrW-1:0] wr_ptr;
  logic [AddrW:0]   count;
  logic [AddrW:0]   count_next;
  logic             pop;

  assign out_valid  = count != '0;
  assign out_data   = mem[rd_ptr];
  assign pop        = out_valid && !out_stall;
  // two free entries so one frame can always land its full pair
  assign room       = count <= (AddrW + 1)'(Depth - 2);
  assign count_next = count + (AddrW + 1)'(push_count) - (AddrW + 1)'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      rd_ptr <= rd_ptr + AddrW'(pop);
      wr_ptr <= wr_ptr + AddrW'(push_count);
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      mem[wr_ptr] <= push0;
    end
    if (push_count == 2'd2) begin
      mem[wr_ptr + AddrW'(1)] <= push1;
    end
  end

endmodule

@@ bench/subcode_section_framer_test.sv @@
`timescale 1ns / 1ps

module subcode_section_framer_test;
  import sscf_pkg::*;

  localparam int SECTION_LEN = 98;
  localparam int BY_MODEL = -1;
  localparam int PHASE_WORDS = 97;
  localparam int STUCK_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam logic [19:0] LIMIT_PLAN = {4'd3, 4'd2, 4'd0, 4'd15, 4'd1};
  localparam result_t NO_WORD = '0;

  typedef struct {
    logic [7:0] symbol;
    logic       s0;
    logic       s1;
    int         typed;
    result_t    a;
    result_t    b;
  } probe_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wen = 1'b0;
  logic [3:0]  cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  subcode_symbol = '0;
  logic        is_sync0 = 1'b0;
  logic        is_sync1 = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_symbol;
  logic [6:0]  position;
  logic        last;
  logic        poor_sync;
  logic [31:0] sections_total;
  logic [31:0] poor_sync_total;
  logic [31:0] sync_lost_total;

  subcode_section_framer #(.SECTION_LEN(SECTION_LEN)) dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_wen         (cfg_wen),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .subcode_symbol  (subcode_symbol),
    .is_sync0        (is_sync0),
    .is_sync1        (is_sync1),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_symbol      (out_symbol),
    .position        (position),
    .last            (last),
    .poor_sync       (poor_sync),
    .sections_total  (sections_total),
    .poor_sync_total (poor_sync_total),
    .sync_lost_total (sync_lost_total)
  );

  initial forever #4 clk = ~clk;

  // framer shadow state
  mode_t       lock_mode = M_SEEK0;
  logic [6:0]  fill = '0;
  logic [7:0]  held_symbol = '0;
  logic        head_sync0 = 1'b0;
  logic        section_bad = 1'b0;
  logic [3:0]  miss_streak = '0;
  logic [3:0]  miss_limit_now = MISS_LIMIT_RESET;
  logic [31:0] n_sections = '0;
  logic [31:0] n_poor = '0;
  logic [31:0] n_lost = '0;

  result_t step_words[$];
  result_t expected_words[$];

  int mismatches = 0;
  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int stuck = 0;
  int disc_pos = 0;
  int flaw_kind = 0;

  probe_t script[14];

  function automatic result_t early_word(input logic [7:0] sym, input logic [6:0] pos);
    result_t w;
    w = '0;
    w.symbol = sym;
    w.position = pos;
    return w;
  endfunction

  task automatic emit_symbol(input logic [7:0] sym);
    result_t w;
    w.symbol = sym;
    w.position = fill;
    w.poor_sync = section_bad;
    fill = fill + 7'd1;
    w.last = (fill >= SECTION_LEN);
    if (w.last) begin
      n_sections = n_sections + 32'd1;
      fill = '0;
      lock_mode = M_NEXT;
      head_sync0 = 1'b0;
      section_bad = 1'b0;
    end
    w.sections_total = n_sections;
    w.poor_sync_total = n_poor;
    w.sync_lost_total = n_lost;
    step_words.push_back(w);
  endtask

  task automatic restart_search(input logic [7:0] sym, input logic s0);
    fill = '0;
    head_sync0 = 1'b0;
    section_bad = 1'b0;
    if (s0) begin
      held_symbol = sym;
      fill = 7'd1;
      lock_mode = M_SEEK1;
    end else begin
      lock_mode = M_SEEK0;
    end
  endtask

  task automatic advance_framer(input logic [7:0] sym, input logic s0, input logic s1);
    logic dropped;
    dropped = 1'b0;
    step_words.delete();
    case (lock_mode)
      M_SEEK0: begin
        restart_search(sym, s0);
      end
      M_SEEK1: begin
        if (s1) begin
          lock_mode = M_INIT;
          section_bad = 1'b0;
          fill = '0;
          emit_symbol(held_symbol);
          emit_symbol(sym);
        end else begin
          lock_mode = M_SEEK0;
          fill = '0;
          head_sync0 = 1'b0;
          section_bad = 1'b0;
        end
      end
      M_INIT: begin
        emit_symbol(sym);
      end
      default: begin
        if (fill == 7'd0) begin
          held_symbol = sym;
          head_sync0 = s0;
          section_bad = 1'b0;
          fill = 7'd1;
        end else if (fill == 7'd1) begin
          if (head_sync0 && s1) begin
            miss_streak = '0;
          end else begin
            if (miss_streak < MISS_RUN_MAX) miss_streak = miss_streak + 4'd1;
            n_poor = n_poor + 32'd1;
            section_bad = 1'b1;
            if (miss_streak >= miss_limit_now) begin
              miss_streak = '0;
              n_lost = n_lost + 32'd1;
              restart_search(sym, s0);
              dropped = 1'b1;
            end
          end
          if (!dropped) begin
            fill = '0;
            emit_symbol(held_symbol);
            emit_symbol(sym);
          end
        end else begin
          emit_symbol(sym);
        end
      end
    endcase
  endtask

  // disc-like frame stream: sync at the head of each section, with flaws and slips
  task automatic next_disc_frame(output logic [7:0] sym, output logic s0, output logic s1);
    sym = 8'($urandom_range(255));
    s0 = ($urandom_range(99) < 2);
    s1 = ($urandom_range(99) < 2);
    if (disc_pos == 0) begin
      flaw_kind = $urandom_range(99);
      if (flaw_kind >= 90) disc_pos = $urandom_range(SECTION_LEN - 1, 1);
    end
    if (disc_pos == 0) s0 = !(flaw_kind >= 55 && flaw_kind < 70) && flaw_kind < 85;
    if (disc_pos == 1) begin
      s1 = !(flaw_kind >= 70 && flaw_kind < 90);
      if (flaw_kind >= 85 && flaw_kind < 90) s0 = 1'b1;
    end
    if ($urandom_range(99) < 3) {s0, s1} = 2'($urandom_range(3));
    disc_pos = (disc_pos + 1) % SECTION_LEN;
  endtask

  task automatic feed_frame(input logic [7:0] sym, input logic s0, input logic s1);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    subcode_symbol <= sym;
    is_sync0 <= s0;
    is_sync1 <= s1;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic pick_idling(input int k);
    case (k % 4)
      0: begin src_idle_pct = 0; sink_stall_pct = 0; end
      1: begin src_idle_pct = 48; sink_stall_pct = 0; end
      2: begin src_idle_pct = 0; sink_stall_pct = 48; end
      default: begin src_idle_pct = 23; sink_stall_pct = 23; end
    endcase
  endtask

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    $display("%0t: %s got %0d want %0d", $time, what, got, want);
  endtask

  always @(posedge clk) begin : sink
    result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < sink_stall_pct);
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          flag_mismatch("word with nothing pending, out_symbol", out_symbol, 0);
        end else begin
          want = expected_words.pop_front();
          if (out_symbol !== want.symbol) flag_mismatch("out_symbol", out_symbol, want.symbol);
          if (position !== want.position) flag_mismatch("position", position, want.position);
          if (last !== want.last) flag_mismatch("last", last, want.last);
          if (poor_sync !== want.poor_sync)
            flag_mismatch("poor_sync", poor_sync, want.poor_sync);
          if (sections_total !== want.sections_total)
            flag_mismatch("sections_total", sections_total, want.sections_total);
          if (poor_sync_total !== want.poor_sync_total)
            flag_mismatch("poor_sync_total", poor_sync_total, want.poor_sync_total);
          if (sync_lost_total !== want.sync_lost_total)
            flag_mismatch("sync_lost_total", sync_lost_total, want.sync_lost_total);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck <= 0;
    end else begin
      stuck <= stuck + 1;
      if (stuck == STUCK_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", STUCK_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int ph;
    int n;
    logic [7:0] sym;
    logic s0;
    logic s1;

    script = '{
      '{8'h00, 1'b0, 1'b0, 0, NO_WORD, NO_WORD},
      '{8'hFF, 1'b0, 1'b1, 0, NO_WORD, NO_WORD},
      '{8'h12, 1'b1, 1'b0, 0, NO_WORD, NO_WORD},
      '{8'h34, 1'b1, 1'b0, 0, NO_WORD, NO_WORD},  // SYNC0 without SYNC1: dropped
      '{8'h56, 1'b0, 1'b1, 0, NO_WORD, NO_WORD},
      '{8'hFF, 1'b1, 1'b1, 0, NO_WORD, NO_WORD},
      '{8'h00, 1'b1, 1'b1, 2, early_word(8'hFF, 7'd0), early_word(8'h00, 7'd1)},
      '{8'hFF, 1'b0, 1'b0, 1, early_word(8'hFF, 7'd2), NO_WORD},
      '{8'h00, 1'b0, 1'b0, 1, early_word(8'h00, 7'd3), NO_WORD},
      '{8'hA5, 1'b1, 1'b0, BY_MODEL, NO_WORD, NO_WORD},
      '{8'h5A, 1'b0, 1'b1, BY_MODEL, NO_WORD, NO_WORD},
      '{8'h80, 1'b1, 1'b1, BY_MODEL, NO_WORD, NO_WORD},
      '{8'h01, 1'b0, 1'b0, BY_MODEL, NO_WORD, NO_WORD},
      '{8'h7F, 1'b0, 1'b0, BY_MODEL, NO_WORD, NO_WORD}
    };

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    pick_idling(3);
    foreach (script[i]) begin
      feed_frame(script[i].symbol, script[i].s0, script[i].s1);
      advance_framer(script[i].symbol, script[i].s0, script[i].s1);
      if (script[i].typed == BY_MODEL) begin
        foreach (step_words[k]) expected_words.push_back(step_words[k]);
      end else begin
        if (script[i].typed >= 1) expected_words.push_back(script[i].a);
        if (script[i].typed == 2) expected_words.push_back(script[i].b);
      end
    end
    disc_pos = 9;

    for (ph = 0; ph < 5; ph++) begin
      in_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clk);
      repeat (DRAIN_CYCLES) @(posedge clk);
      cfg_wen <= 1'b1;
      cfg_wdata <= LIMIT_PLAN[ph*4 +: 4];
      @(posedge clk);
      cfg_wen <= 1'b0;
      miss_limit_now = LIMIT_PLAN[ph*4 +: 4];
      pick_idling(ph);
      for (n = 0; n < PHASE_WORDS; n++) begin
        next_disc_frame(sym, s0, s1);
        feed_frame(sym, s0, s1);
        advance_framer(sym, s0, s1);
        foreach (step_words[k]) expected_words.push_back(step_words[k]);
      end
    end

    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ subcode_section_framer.f @@
rtl/core/sscf_pkg.sv
rtl/core/sscf_step.sv
rtl/core/sscf_out_fifo.sv
rtl/core/subcode_section_framer.sv
bench/subcode_section_framer_test.sv
